@@ rtl/xdfs_pkg.sv @@
// Shared constants, codes and handshake structs for the frame store.
// No dependencies; used by xdfs_ctrl, xdfs_datapath and the top level.
`timescale 1ns / 1ps

package xdfs_pkg;

  localparam int unsigned SCREEN_BYTES_I = 32000;
  localparam int unsigned SCREEN_LONGS   = SCREEN_BYTES_I / 4;
  localparam int unsigned LONG_AW        = $clog2(SCREEN_LONGS);

  localparam logic [15:0] SCREEN_BYTES = 16'(SCREEN_BYTES_I);

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_DELTA = 2'd1;
  localparam logic [1:0] OP_EMIT  = 2'd2;

  localparam logic [1:0] MODE_4P = 2'd0;
  localparam logic [1:0] MODE_2P = 2'd1;

  localparam logic [5:0] LAST_GROUP_320 = 6'd19;
  localparam logic [5:0] LAST_GROUP_640 = 6'd39;

  typedef struct packed {
    logic latch;
    logic mem_wr;
    logic delta;
    logic rd_item;
    logic rd_fetch;
    logic capture;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic fetch_done;
  } stat_t;

endpackage

@@ rtl/xdfs_ctrl.sv @@
// Sequencer for load, delta and emit requests.
// Depends on xdfs_pkg; drives the command struct of xdfs_datapath.
`timescale 1ns / 1ps

module xdfs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         operation,
  input  xdfs_pkg::stat_t    stat,
  output xdfs_pkg::cmd_t     cmd,
  output logic               busy
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_DRD   = 7'b0000100,
    S_DWR   = 7'b0001000,
    S_FETCH = 7'b0010000,
    S_CAPT  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          unique case (operation)
            xdfs_pkg::OP_LOAD:  state_next = S_LOAD;
            xdfs_pkg::OP_DELTA: state_next = S_DRD;
            xdfs_pkg::OP_EMIT:  state_next = S_FETCH;
            default:            state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd.mem_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_DRD: begin
        cmd.rd_item = 1'b1;
        state_next  = S_DWR;
      end
      S_DWR: begin
        cmd.mem_wr = 1'b1;
        cmd.delta  = 1'b1;
        state_next = S_IDLE;
      end
      S_FETCH: begin
        cmd.rd_fetch = 1'b1;
        state_next   = S_CAPT;
      end
      S_CAPT: begin
        cmd.capture = 1'b1;
        state_next  = stat.fetch_done ? S_DONE : S_FETCH;
      end
      S_DONE: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

@@ rtl/xdfs_datapath.sv @@
// Screen memory, read pointer, row counter, mode register and pixel assembly.
// Depends on xdfs_pkg; commanded by xdfs_ctrl.
`timescale 1ns / 1ps

module xdfs_datapath (
  input  logic               clk,
  input  logic               rst,
  input  xdfs_pkg::cmd_t     cmd,
  output xdfs_pkg::stat_t    stat,
  input  logic [15:0]        byte_offset,
  input  logic [31:0]        long_value,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_data,
  output logic [63:0]        pixels,
  output logic               last_in_row,
  output logic               last_in_frame,
  output logic               done
);

  logic [31:0] mem [xdfs_pkg::SCREEN_LONGS];
  logic [31:0] rdata;

  logic [1:0]  mode;
  logic [14:0] rp;
  logic [5:0]  gir;
  logic [2:0]  k;
  logic [15:0] off_r;
  logic [31:0] val_r;
  logic [15:0] words [4];

  logic [2:0]  planes;
  logic        has2;
  logic        has4;
  logic [3:0]  step;
  logic [5:0]  last_group;
  logic [15:0] fa_raw;
  logic [15:0] fa;
  logic        in_range;
  logic [xdfs_pkg::LONG_AW-1:0] mem_addr;
  logic [2:0]  k_adv;
  logic [15:0] rp_sum;
  logic        frame_end;
  logic        row_end;
  logic [63:0] pix;

  assign has4       = (mode == xdfs_pkg::MODE_4P);
  assign has2       = has4 || (mode == xdfs_pkg::MODE_2P);
  assign planes     = has4 ? 3'd4 : (has2 ? 3'd2 : 3'd1);
  assign step       = {planes, 1'b0};
  assign last_group = has4 ? xdfs_pkg::LAST_GROUP_320 : xdfs_pkg::LAST_GROUP_640;

  assign fa_raw   = {1'b0, rp} + {12'd0, k, 1'b0};
  assign fa       = (fa_raw >= xdfs_pkg::SCREEN_BYTES) ? fa_raw - xdfs_pkg::SCREEN_BYTES
                                                       : fa_raw;
  assign in_range = (off_r < xdfs_pkg::SCREEN_BYTES);
  assign mem_addr = cmd.rd_fetch ? fa[xdfs_pkg::LONG_AW+1:2]
                                 : off_r[xdfs_pkg::LONG_AW+1:2];

  assign k_adv           = k + (fa[1] ? 3'd1 : 3'd2);
  assign stat.fetch_done = (k_adv >= planes);

  assign rp_sum    = {1'b0, rp} + {12'd0, step};
  assign frame_end = (rp_sum >= xdfs_pkg::SCREEN_BYTES);
  assign row_end   = frame_end || (gir >= last_group);

  always_comb begin
    for (int b = 0; b < 16; b++) begin
      pix[b*4 +: 4] = {words[3][b] & has4, words[2][b] & has4,
                       words[1][b] & has2, words[0][b]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && in_range) begin
      mem[off_r[xdfs_pkg::LONG_AW+1:2]] <= cmd.delta ? (rdata ^ val_r) : val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_fetch || (cmd.rd_item && in_range)) begin
      rdata <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      off_r <= byte_offset;
      val_r <= long_value;
    end
    if (cmd.capture) begin
      if (fa[1]) begin
        words[k[1:0]] <= rdata[15:0];
      end else begin
        words[k[1:0]] <= rdata[31:16];
        if ((k + 3'd1) < planes) begin
          words[k[1:0] + 2'd1] <= rdata[15:0];
        end
      end
    end
    if (cmd.emit) begin
      pixels        <= pix;
      last_in_row   <= row_end;
      last_in_frame <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= xdfs_pkg::MODE_4P;
      rp   <= '0;
      gir  <= '0;
      k    <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cfg_write) begin
        mode <= cfg_data;
      end
      if (cmd.latch) begin
        k <= '0;
      end else if (cmd.capture) begin
        k <= k_adv;
      end
      if (cmd.emit) begin
        if (frame_end) begin
          rp  <= '0;
          gir <= '0;
        end else begin
          rp  <= rp_sum[14:0];
          gir <= row_end ? 6'd0 : gir + 6'd1;
        end
      end
    end
  end

  a_rp_bounds: assert property (@(posedge clk) disable iff (rst)
    (rp < xdfs_pkg::SCREEN_BYTES[14:0]) && !rp[0])
    else $error("read pointer out of range or odd");

  a_emit_strobe: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> done)
    else $error("emit without result strobe");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    done && last_in_frame |-> last_in_row && (rp == '0) && (gir == '0))
    else $error("frame end without row end or pointer wrap");

  a_capture_word: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (k < planes))
    else $error("plane word captured beyond plane count");

endmodule

@@ rtl/xor_delta_frame_store_planar_scanout.sv @@
// Top level of the planar frame store with XOR deltas and chunky scanout.
// Depends on xdfs_pkg, xdfs_ctrl and xdfs_datapath.
//
//  channel   ports                                      handshake
//  request   operation, byte_offset, long_value         start && !busy
//  result    pixels, last_in_row, last_in_frame         done, one cycle
//  config    cfg_data (resolution mode)                 cfg_write
//
// Load writes a longword, delta reads then writes back; unused codes idle.
// Emit reads one longword in 1-plane mode, one or two in 2-plane mode and
// two or three in 4-plane mode from the single-port screen memory with
// registered read. Reset sets 4-plane mode and clears pointer and row
// count, not the memory. The receiver cannot stall: done is a strobe.
`timescale 1ns / 1ps

module xor_delta_frame_store_planar_scanout (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [15:0] byte_offset,
  input  logic [31:0] long_value,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_data,
  output logic        done,
  output logic [63:0] pixels,
  output logic        last_in_row,
  output logic        last_in_frame
);

  xdfs_pkg::cmd_t  cmd;
  xdfs_pkg::stat_t stat;

  xdfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  xdfs_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .byte_offset   (byte_offset),
    .long_value    (long_value),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .pixels        (pixels),
    .last_in_row   (last_in_row),
    .last_in_frame (last_in_frame),
    .done          (done)
  );

endmodule

@@ tb/xor_delta_frame_store_planar_scanout_test.sv @@
// Self-checking testbench for the planar frame store with XOR deltas and chunky scanout.
// Drives load, delta and emit requests, predicts each pixel group and checks every result.
// Depends on xdfs_pkg and the top level xor_delta_frame_store_planar_scanout.
`timescale 1ns / 1ps

module xor_delta_frame_store_planar_scanout_test;

  localparam logic [1:0] OP_SPARE      = 2'd3;
  localparam logic [1:0] MODE_1P       = 2'd2;
  localparam logic [1:0] MODE_1P_ALIAS = 2'd3;
  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 560;
  localparam int SETTLE_CYCLES = 12;
  localparam int FILL_LONGS   = 450;
  localparam int FILL_BYTES   = FILL_LONGS * 4;
  localparam int SKEWED_GROUPS = 24;

  typedef struct packed {
    logic [63:0] pixels;
    logic        row_end;
    logic        frame_end;
  } group_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  operation = xdfs_pkg::OP_LOAD;
  logic [15:0] byte_offset = '0;
  logic [31:0] long_value = '0;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_data = xdfs_pkg::MODE_4P;
  logic        busy;
  logic        done;
  logic [63:0] pixels;
  logic        last_in_row;
  logic        last_in_frame;

  logic [31:0] shadow_screen [xdfs_pkg::SCREEN_LONGS];
  logic [14:0] scan_pos = '0;
  logic [5:0]  scan_group = '0;
  logic [1:0]  scan_mode = xdfs_pkg::MODE_4P;
  group_t      pending_groups [$];
  group_t      want_group;
  int          errors = 0;
  int          items_sent = 0;
  int          groups_checked = 0;
  int          stall_cycles = 0;
  bit          quiet = 1'b0;

  xor_delta_frame_store_planar_scanout dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .byte_offset   (byte_offset),
    .long_value    (long_value),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .done          (done),
    .pixels        (pixels),
    .last_in_row   (last_in_row),
    .last_in_frame (last_in_frame)
  );

  always #6 clk = ~clk;

  function automatic logic [15:0] plane_word(int addr);
    int          a;
    logic [31:0] lw;
    a = addr;
    if (a >= xdfs_pkg::SCREEN_BYTES_I) a -= xdfs_pkg::SCREEN_BYTES_I;
    lw = shadow_screen[a >> 2];
    return a[1] ? lw[15:0] : lw[31:16];
  endfunction

  task automatic model_request(logic [1:0] op, logic [15:0] off, logic [31:0] val);
    int          planes;
    int          stride;
    logic [5:0]  last_group;
    logic [15:0] words [4];
    group_t      g;
    case (op)
      xdfs_pkg::OP_LOAD, xdfs_pkg::OP_DELTA: begin
        if (off < xdfs_pkg::SCREEN_BYTES) begin
          if (op == xdfs_pkg::OP_LOAD) shadow_screen[off[14:2]] = val;
          else shadow_screen[off[14:2]] ^= val;
        end
      end
      xdfs_pkg::OP_EMIT: begin
        case (scan_mode)
          xdfs_pkg::MODE_4P: begin
            planes = 4;
            last_group = xdfs_pkg::LAST_GROUP_320;
          end
          xdfs_pkg::MODE_2P: begin
            planes = 2;
            last_group = xdfs_pkg::LAST_GROUP_640;
          end
          default: begin
            planes = 1;
            last_group = xdfs_pkg::LAST_GROUP_640;
          end
        endcase
        stride = planes * 2;
        for (int n = 0; n < 4; n++)
          words[n] = (n < planes) ? plane_word(int'(scan_pos) + 2 * n) : 16'h0000;
        g.pixels = '0;
        for (int b = 0; b < 16; b++)
          for (int n = 0; n < 4; n++)
            g.pixels[b * 4 + n] = words[n][b];
        g.frame_end = (int'(scan_pos) + stride) >= xdfs_pkg::SCREEN_BYTES_I;
        g.row_end = g.frame_end || (scan_group >= last_group);
        if (g.frame_end) begin
          scan_pos = '0;
          scan_group = '0;
        end else begin
          scan_pos = 15'(int'(scan_pos) + stride);
          scan_group = g.row_end ? 6'd0 : scan_group + 6'd1;
        end
        pending_groups.push_back(g);
      end
      default: ;
    endcase
  endtask

  task automatic send_request(logic [1:0] op, logic [15:0] off, logic [31:0] val);
    bit taken;
    if (!quiet && $urandom_range(99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    byte_offset <= off;
    long_value <= val;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    model_request(op, off, val);
    items_sent++;
  endtask

  // drop start and hold until every pixel group is back and the block is quiet
  task automatic settle();
    start <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    settle();
    cfg_write <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
    scan_mode = m;
  endtask

  task automatic test_fill_memory();
    for (int i = 0; i < FILL_LONGS; i++) begin
      quiet = (i < FILL_LONGS / 2);
      send_request(xdfs_pkg::OP_LOAD, 16'(i * 4 + $urandom_range(3)), $urandom());
    end
    quiet = 1'b0;
  endtask

  task automatic test_directed_cases();
    write_mode(xdfs_pkg::MODE_4P);
    send_request(xdfs_pkg::OP_LOAD, 16'd0, 32'hFFFF_FFFF);
    send_request(xdfs_pkg::OP_LOAD, 16'd4, 32'h0000_0000);
    send_request(xdfs_pkg::OP_EMIT, 16'd0, 32'd0);
    send_request(xdfs_pkg::OP_LOAD, 16'd8, 32'hAAAA_5555);
    send_request(xdfs_pkg::OP_LOAD, 16'd12, 32'h0F0F_F0F0);
    send_request(xdfs_pkg::OP_EMIT, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(xdfs_pkg::OP_LOAD, 16'd16, 32'h1234_5678);
    send_request(xdfs_pkg::OP_DELTA, 16'd17, 32'hFFFF_0000);
    send_request(xdfs_pkg::OP_DELTA, 16'd19, 32'h0000_FFFF);
    send_request(xdfs_pkg::OP_EMIT, 16'd0, 32'd0);
    send_request(xdfs_pkg::OP_LOAD, xdfs_pkg::SCREEN_BYTES - 16'd4, 32'hDEAD_BEEF);
    send_request(xdfs_pkg::OP_DELTA, xdfs_pkg::SCREEN_BYTES - 16'd1, 32'h8000_0001);
    send_request(xdfs_pkg::OP_LOAD, xdfs_pkg::SCREEN_BYTES, 32'hFFFF_FFFF);
    send_request(xdfs_pkg::OP_DELTA, xdfs_pkg::SCREEN_BYTES + 16'd3, 32'hFFFF_FFFF);
    send_request(xdfs_pkg::OP_LOAD, 16'hFFFF, 32'h0000_0000);
    send_request(xdfs_pkg::OP_DELTA, 16'hFFFC, 32'hFFFF_FFFF);
    send_request(OP_SPARE, 16'd24, 32'hFFFF_FFFF);
    write_mode(xdfs_pkg::MODE_2P);
    send_request(xdfs_pkg::OP_EMIT, 16'd0, 32'd0);
    send_request(xdfs_pkg::OP_EMIT, 16'd0, 32'd0);
    write_mode(MODE_1P);
    send_request(xdfs_pkg::OP_EMIT, 16'd0, 32'd0);
    send_request(xdfs_pkg::OP_EMIT, 16'd0, 32'd0);
    write_mode(MODE_1P_ALIAS);
    send_request(xdfs_pkg::OP_EMIT, 16'd0, 32'd0);
    send_request(xdfs_pkg::OP_EMIT, 16'd0, 32'd0);
    write_mode(xdfs_pkg::MODE_4P);
    send_request(xdfs_pkg::OP_EMIT, 16'd0, 32'd0);
  endtask

  task automatic test_skewed_fetch();
    // misalign the pointer so each 4-plane group straddles three longwords
    write_mode(MODE_1P);
    while (scan_pos[2:0] != 3'd2) send_request(xdfs_pkg::OP_EMIT, 16'd0, 32'd0);
    write_mode(xdfs_pkg::MODE_4P);
    repeat (SKEWED_GROUPS) begin
      if ($urandom_range(99) < 8)
        send_request(xdfs_pkg::OP_DELTA, 16'($urandom_range(FILL_BYTES - 1)), $urandom());
      else
        send_request(xdfs_pkg::OP_EMIT, 16'($urandom()), $urandom());
    end
    write_mode(xdfs_pkg::MODE_2P);
    send_request(xdfs_pkg::OP_EMIT, 16'd0, 32'd0);
    write_mode(MODE_1P);
    send_request(xdfs_pkg::OP_EMIT, 16'd0, 32'd0);
  endtask

  task automatic test_random_traffic();
    int sent;
    int phase;
    int len;
    int r;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      write_mode(phase < 4 ? 2'(phase) : 2'($urandom_range(3)));
      quiet = (phase == 5);
      len = $urandom_range(150, 40);
      repeat (len) begin
        r = $urandom_range(99);
        if (r < 50 && int'(scan_pos) + 8 <= FILL_BYTES)
          send_request(xdfs_pkg::OP_EMIT, 16'($urandom()), $urandom());
        else if (r < 70)
          send_request(xdfs_pkg::OP_DELTA, 16'($urandom_range(FILL_BYTES - 1)), $urandom());
        else if (r < 85)
          send_request(xdfs_pkg::OP_LOAD, 16'($urandom_range(xdfs_pkg::SCREEN_BYTES_I - 1)),
                       $urandom());
        else if (r < 90)
          send_request(OP_SPARE, 16'($urandom()), $urandom());
        else
          send_request(2'($urandom_range(1)),
                       16'($urandom_range(65535, xdfs_pkg::SCREEN_BYTES_I)), $urandom());
        sent++;
        if ($urandom_range(199) == 0) settle();
      end
      phase++;
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_groups.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got pixels %h", $time, pixels);
      end else begin
        want_group = pending_groups.pop_front();
        groups_checked++;
        if (pixels !== want_group.pixels) begin
          errors++;
          $display("%0t: pixels expected %h got %h", $time, want_group.pixels, pixels);
        end
        if (last_in_row !== want_group.row_end) begin
          errors++;
          $display("%0t: last_in_row expected %b got %b", $time, want_group.row_end,
                   last_in_row);
        end
        if (last_in_frame !== want_group.frame_end) begin
          errors++;
          $display("%0t: last_in_frame expected %b got %b", $time, want_group.frame_end,
                   last_in_frame);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d groups outstanding", $time,
               STALL_LIMIT, pending_groups.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_memory();
    test_directed_cases();
    test_skewed_fetch();
    test_random_traffic();
    settle();
    repeat (20) @(posedge clk);
    $display("Sent %0d requests across all four mode settings; checked %0d pixel groups,",
             items_sent, groups_checked);
    $display("including row ends, out-of-range writes and groups straddling longwords.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/xdfs_pkg.sv
rtl/xdfs_ctrl.sv
rtl/xdfs_datapath.sv
rtl/xor_delta_frame_store_planar_scanout.sv
tb/xor_delta_frame_store_planar_scanout_test.sv
